@@ rtl/vec3_normalize_top_assert.svh @@
// ----------------------------------------------------------------------------
// vec3_normalize_top_assert.svh
// Assertion macros used by the vector normalizer checker.
// ----------------------------------------------------------------------------
`ifndef VEC3_NORMALIZE_TOP_ASSERT_SVH
`define VEC3_NORMALIZE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define VN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define VN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/vn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_pkg
// Shared widths and constants of the fixed-point vector normalizer.
// ----------------------------------------------------------------------------
package vn_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COMP_W        = 32;   // input component width
    localparam int SQ_W          = 64;   // squared length width
    localparam int ROOT_W        = 32;   // square root width
    localparam int ROOT_REM_W    = 33;   // square root remainder width
    localparam int SQRT_STEPS    = 32;   // one root bit per stage
    localparam int QUO_W         = 33;   // divider quotient width
    localparam int DIV_STEPS     = 33;   // one quotient bit per stage
    localparam int DIVD_W        = 64;   // divider dividend width
    localparam int M_W           = 5;    // normalizing shift count width
    localparam int INV_W         = 32;   // reciprocal output width
    localparam int DIV_LANES     = 4;    // three components plus reciprocal
    localparam int SHIFT_STAGES  = 5;    // shift by 16, 8, 4, 2, 1 pairs
endpackage

@@ rtl/vn_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_front
// Magnitude split, squaring, summing and normalizing shift of the squared
// length: nine register stages.
// ----------------------------------------------------------------------------
module vn_front
    import vn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic [COMP_W-1:0]       i_comp [3],
    output logic                    o_vld,
    output logic [SQ_W-1:0]         o_t,
    output logic [M_W-1:0]          o_m,
    output logic                    o_zero,
    output logic                    o_unit,
    output logic [2:0]              o_neg,
    output logic [FRAC_BITS+1:0]    o_orig [3],
    output logic [COMP_W-1:0]       o_magsh [3]
);
    localparam int UNIT_W = FRAC_BITS + 2;
    localparam int NST    = 4 + SHIFT_STAGES;

    logic [NST-1:0]      r_vld;
    logic [COMP_W-1:0]   r_mag1 [3];
    logic [SQ_W-1:0]     r_sq2  [3];
    logic [COMP_W-1:0]   r_mag2 [3];
    logic [SQ_W-1:0]     r_sum3;
    logic [COMP_W-1:0]   r_mag3 [3];
    logic [2:0]          r_neg  [0:NST-1];
    logic [UNIT_W-1:0]   r_orig [0:NST-1][3];
    logic [SQ_W-1:0]     r_t    [0:SHIFT_STAGES];
    logic [M_W-1:0]      r_m    [0:SHIFT_STAGES];
    logic [COMP_W-1:0]   r_msh  [0:SHIFT_STAGES][3];
    logic                r_zero [0:SHIFT_STAGES];
    logic                r_unit [0:SHIFT_STAGES];

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_vld};
        end
    end

    // stages one to four: magnitude, square, sum, flags
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_mag1[i]     <= i_comp[i][COMP_W-1] ? (~i_comp[i] + 1'b1) : i_comp[i];
                r_orig[0][i]  <= i_comp[i][UNIT_W-1:0];
                r_neg[0][i]   <= i_comp[i][COMP_W-1];
                r_sq2[i]      <= SQ_W'(r_mag1[i]) * SQ_W'(r_mag1[i]);
                r_mag2[i]     <= r_mag1[i];
                r_mag3[i]     <= r_mag2[i];
                r_msh[0][i]   <= r_mag3[i];
            end
            r_sum3    <= r_sq2[0] + r_sq2[1] + r_sq2[2];
            r_t[0]    <= r_sum3;
            r_m[0]    <= '0;
            r_zero[0] <= (r_sum3 == '0);
            r_unit[0] <= (r_sum3 == (SQ_W'(1) << (2 * FRAC_BITS)));
            for (int s = 1; s < NST; s++) begin
                r_neg[s]  <= r_neg[s-1];
                r_orig[s] <= r_orig[s-1];
            end
        end
    end

    // shift stages: drop leading zero pairs, coarse first
    for (genvar g = 0; g < SHIFT_STAGES; g++) begin : g_shift
        localparam int K = (1 << (SHIFT_STAGES - 1)) >> g;
        logic hit;
        assign hit = (r_t[g][SQ_W-1 -: 2*K] == '0);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[g+1]    <= hit ? (r_t[g] << (2*K)) : r_t[g];
                r_m[g+1]    <= hit ? (r_m[g] + M_W'(K)) : r_m[g];
                r_zero[g+1] <= r_zero[g];
                r_unit[g+1] <= r_unit[g];
                for (int i = 0; i < 3; i++) begin
                    r_msh[g+1][i] <= hit ? (r_msh[g][i] << K) : r_msh[g][i];
                end
            end
        end
    end

    assign o_vld   = r_vld[NST-1];
    assign o_t     = r_t[SHIFT_STAGES];
    assign o_m     = r_m[SHIFT_STAGES];
    assign o_zero  = r_zero[SHIFT_STAGES];
    assign o_unit  = r_unit[SHIFT_STAGES];
    assign o_neg   = r_neg[NST-1];
    assign o_orig  = r_orig[NST-1];
    assign o_magsh = r_msh[SHIFT_STAGES];
endmodule

@@ rtl/vn_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_sqrt
// Pipelined integer square root, one root bit per stage, with a side
// payload that travels alongside.
// ----------------------------------------------------------------------------
module vn_sqrt
    import vn_pkg::*;
#(
    parameter int SIDE_W = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [SQ_W-1:0]    i_rad,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_vld,
    output logic [ROOT_W-1:0]  o_root,
    output logic [SIDE_W-1:0]  o_side
);
    localparam int TRIAL_W = ROOT_REM_W + 2;

    logic [SQRT_STEPS:0]      r_vld;
    logic [SQ_W-1:0]          r_rad  [0:SQRT_STEPS];
    logic [ROOT_REM_W-1:0]    r_rem  [0:SQRT_STEPS];
    logic [ROOT_W-1:0]        r_root [0:SQRT_STEPS];
    logic [SIDE_W-1:0]        r_side [0:SQRT_STEPS];

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQRT_STEPS-1:0], i_vld};
        end
    end

    // load radicand
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    // one root bit per stage
    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
        logic [TRIAL_W-1:0] trial;
        logic [TRIAL_W-1:0] cand;
        logic               ge;
        assign trial = {r_rem[g], r_rad[g][SQ_W-1 -: 2]};
        assign cand  = TRIAL_W'({r_root[g], 2'b01});
        assign ge    = (trial >= cand);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[g+1]  <= r_rad[g] << 2;
                r_rem[g+1]  <= ge ? ROOT_REM_W'(trial - cand) : ROOT_REM_W'(trial);
                r_root[g+1] <= {r_root[g][ROOT_W-2:0], ge};
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_vld  = r_vld[SQRT_STEPS];
    assign o_root = r_root[SQRT_STEPS];
    assign o_side = r_side[SQRT_STEPS];
endmodule

@@ rtl/vn_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_div
// Pipelined restoring divider, several lanes sharing one divisor, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module vn_div
    import vn_pkg::*;
#(
    parameter int SIDE_W = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic [ROOT_W-1:0]                 i_divisor,
    input  logic [DIV_LANES-1:0][DIVD_W-1:0]  i_dividend,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_vld,
    output logic [DIV_LANES-1:0][QUO_W-1:0]   o_quo,
    output logic [SIDE_W-1:0]                 o_side
);
    localparam int T_W = ROOT_W + 1;

    logic [DIV_STEPS:0]                r_vld;
    logic [DIV_LANES-1:0][ROOT_W-1:0]  r_rem  [0:DIV_STEPS];
    logic [DIV_LANES-1:0][QUO_W-1:0]   r_lo   [0:DIV_STEPS];
    logic [ROOT_W-1:0]                 r_dvs  [0:DIV_STEPS];
    logic [SIDE_W-1:0]                 r_side [0:DIV_STEPS];

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STEPS-1:0], i_vld};
        end
    end

    // load: upper dividend bits start the remainder, they stay below the divisor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < DIV_LANES; l++) begin
                r_rem[0][l] <= ROOT_W'(i_dividend[l][DIVD_W-1:QUO_W]);
                r_lo[0][l]  <= i_dividend[l][QUO_W-1:0];
            end
            r_dvs[0]  <= i_divisor;
            r_side[0] <= i_side;
        end
    end

    // one quotient bit per stage, shifted in behind the dividend bits
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic [DIV_LANES-1:0][T_W-1:0] t;
        logic [DIV_LANES-1:0]          ge;
        always_comb begin
            for (int l = 0; l < DIV_LANES; l++) begin
                t[l]  = {r_rem[g][l], r_lo[g][l][QUO_W-1]};
                ge[l] = (t[l] >= T_W'(r_dvs[g]));
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < DIV_LANES; l++) begin
                    r_rem[g+1][l] <= ge[l] ? ROOT_W'(t[l] - T_W'(r_dvs[g]))
                                           : ROOT_W'(t[l]);
                    r_lo[g+1][l]  <= {r_lo[g][l][QUO_W-2:0], ge[l]};
                end
                r_dvs[g+1]  <= r_dvs[g];
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_vld  = r_vld[DIV_STEPS];
    assign o_quo  = r_lo[DIV_STEPS];
    assign o_side = r_side[DIV_STEPS];
endmodule

@@ rtl/vec3_normalize_top.sv @@
`timescale 1ns / 1ps
// An input beat passes the front end, the square root, the divider and the output register.
// Throughput: one vector per cycle unless the output stalls; the root and the four
// divisions are fully pipelined, one bit per stage, so a new beat enters every cycle that the output does not stall.
// A stall on the output freezes the whole pipeline; no beat is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// vec3_normalize_top
// Fixed-point 3D vector normalizer: unit vector and reciprocal length.
// ----------------------------------------------------------------------------
module vec3_normalize_top
    import vn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // vec_x[31:0], vec_y[63:32], vec_z[95:64]
    input  logic [3*COMP_W-1:0]   s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // unit_x, unit_y, unit_z (FRAC_BITS+2 each), inv_length (32), zero pad
    output logic [((3*(FRAC_BITS+2)+INV_W+7)/8)*8-1:0] m_axis_tdata,
    // zero_vector
    output logic [0:0]            m_axis_tuser
);
    localparam int UNIT_W  = FRAC_BITS + 2;
    localparam int OUT_W   = ((3*UNIT_W + INV_W + 7) / 8) * 8;
    localparam int SQ_SIDE = 3 + 1 + 1 + M_W + 3*UNIT_W + 3*COMP_W;
    localparam int DV_SIDE = 3 + 1 + 1 + 1 + 3*UNIT_W;
    localparam int E_W     = 7;

    logic                en;
    logic [COMP_W-1:0]   comp [3];

    logic                f_vld, f_zero, f_unit;
    logic [SQ_W-1:0]     f_t;
    logic [M_W-1:0]      f_m;
    logic [2:0]          f_neg;
    logic [UNIT_W-1:0]   f_orig [3];
    logic [COMP_W-1:0]   f_msh  [3];

    logic                sq_vld;
    logic [ROOT_W-1:0]   sq_root;
    logic [SQ_SIDE-1:0]  sq_side_in, sq_side;

    logic [2:0]          s_neg;
    logic                s_zero, s_unit;
    logic [M_W-1:0]      s_m;
    logic [3*UNIT_W-1:0] s_orig;
    logic [3*COMP_W-1:0] s_msh;
    logic [E_W-1:0]      inv_exp;
    logic                inv_sat;
    logic [DIV_LANES-1:0][DIVD_W-1:0] dvd;
    logic [DV_SIDE-1:0]  dv_side_in, dv_side;

    logic                d_vld;
    logic [DIV_LANES-1:0][QUO_W-1:0] d_quo;
    logic [2:0]          d_neg;
    logic                d_zero, d_unit, d_sat;
    logic [3*UNIT_W-1:0] d_orig;

    logic                r_out_vld;
    logic [UNIT_W-1:0]   r_unit_q [3];
    logic [INV_W-1:0]    r_inv;
    logic                r_zero;
    logic [UNIT_W-1:0]   n_unit_q [3];
    logic [INV_W-1:0]    n_inv;

    // whole pipeline moves when the output register is free or being taken
    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            comp[i] = s_axis_tdata[i*COMP_W +: COMP_W];
        end
    end

    vn_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_axis_tvalid),
        .i_comp  (comp),
        .o_vld   (f_vld),
        .o_t     (f_t),
        .o_m     (f_m),
        .o_zero  (f_zero),
        .o_unit  (f_unit),
        .o_neg   (f_neg),
        .o_orig  (f_orig),
        .o_magsh (f_msh)
    );

    assign sq_side_in = {f_neg, f_zero, f_unit, f_m,
                         f_orig[2], f_orig[1], f_orig[0],
                         f_msh[2], f_msh[1], f_msh[0]};

    vn_sqrt #(.SIDE_W(SQ_SIDE)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_rad   (f_t),
        .i_side  (sq_side_in),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign {s_neg, s_zero, s_unit, s_m, s_orig, s_msh} = sq_side;

    // form dividends: component scaled by 2^(F+m), reciprocal numerator 2^(2F+m)
    always_comb begin
        inv_exp = E_W'(2 * FRAC_BITS) + E_W'(s_m);
        inv_sat = (inv_exp >= E_W'(DIVD_W));
        for (int i = 0; i < 3; i++) begin
            dvd[i] = DIVD_W'(s_msh[i*COMP_W +: COMP_W]) << FRAC_BITS;
        end
        dvd[3] = inv_sat ? '0 : (DIVD_W'(1) << inv_exp[5:0]);
    end

    assign dv_side_in = {s_neg, s_zero, s_unit, inv_sat, s_orig};

    vn_div #(.SIDE_W(DV_SIDE)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (sq_vld),
        .i_divisor  (sq_root),
        .i_dividend (dvd),
        .i_side     (dv_side_in),
        .o_vld      (d_vld),
        .o_quo      (d_quo),
        .o_side     (dv_side)
    );

    assign {d_neg, d_zero, d_unit, d_sat, d_orig} = dv_side;

    // select special cases, apply signs, saturate the reciprocal
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (d_zero) begin
                n_unit_q[i] = '0;
            end else if (d_unit) begin
                n_unit_q[i] = d_orig[i*UNIT_W +: UNIT_W];
            end else if (d_neg[i]) begin
                n_unit_q[i] = UNIT_W'(-d_quo[i][UNIT_W-1:0]);
            end else begin
                n_unit_q[i] = d_quo[i][UNIT_W-1:0];
            end
        end
        if (d_zero) begin
            n_inv = '0;
        end else if (d_unit) begin
            n_inv = INV_W'(1) << FRAC_BITS;
        end else if (d_sat || d_quo[3][QUO_W-1]) begin
            n_inv = '1;
        end else begin
            n_inv = d_quo[3][INV_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_unit_q <= n_unit_q;
            r_inv    <= n_inv;
            r_zero   <= d_zero;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_W'({r_inv, r_unit_q[2], r_unit_q[1], r_unit_q[0]});
    assign m_axis_tuser  = r_zero;
endmodule

@@ rtl/vn_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_checker
// Port-level checks of the vector normalizer output stream.
// ----------------------------------------------------------------------------
`include "vec3_normalize_top_assert.svh"

module vn_checker
    import vn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_tvalid,
    input logic                  i_tready,
    input logic [((3*(FRAC_BITS+2)+INV_W+7)/8)*8-1:0] i_tdata,
    input logic [0:0]            i_tuser
);
    localparam int INV_LSB = 3 * (FRAC_BITS + 2);

    // a stalled beat holds
    `VN_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_tvalid && !i_tready, i_tvalid && $stable(i_tdata), "stalled beat changed")
    // a zero vector gives all-zero payload
    `VN_ASSERT_NOW(a_zero, i_clk, i_rst_n, i_tvalid && i_tuser[0], i_tdata == '0, "zero vector payload not zero")
    // any other vector has a nonzero reciprocal length
    `VN_ASSERT_NOW(a_inv, i_clk, i_rst_n, i_tvalid && !i_tuser[0], i_tdata[INV_LSB +: INV_W] != '0, "reciprocal is zero")
endmodule

bind vec3_normalize_top vn_checker #(.FRAC_BITS(FRAC_BITS)) u_vn_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_tvalid (m_axis_tvalid),
    .i_tready (m_axis_tready),
    .i_tdata  (m_axis_tdata),
    .i_tuser  (m_axis_tuser)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vec3_normalize_top: random and directed vectors,
// random idling on both sides, one long output stall, in-order result check.
// ----------------------------------------------------------------------------
module testbench;
    import vn_pkg::*;

    localparam int FB      = FRAC_BITS_DEF;
    localparam int UW      = FB + 2;
    localparam int OUT_W   = ((3*UW+INV_W+7)/8)*8;
    localparam int LATENCY = 77;
    localparam int WD_MAX  = 20000;

    typedef struct packed {
        logic [UW-1:0]    ux;
        logic [UW-1:0]    uy;
        logic [UW-1:0]    uz;
        logic [INV_W-1:0] inv_len;
        logic             zero;
    } t_unit_res;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [3*COMP_W-1:0] s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic [0:0]          m_axis_tuser;

    logic [3*COMP_W-1:0] vec_queue[$];
    t_unit_res           unit_expected[$];
    int                  mismatches = 0;
    int                  checked = 0;
    int                  zero_seen = 0;
    int                  watchdog = 0;
    int                  send_gap = 0;
    int                  recv_gap = 0;
    int                  hold_cycles = 0;
    bit                  hold_done = 1'b0;
    bit                  stim_done = 1'b0;

    vec3_normalize_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Bitwise integer square root, floor
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Normalize one vector: unit components and saturated reciprocal length
    function automatic t_unit_res normalize_vec(input logic [3*COMP_W-1:0] v);
        t_unit_res     r;
        logic [63:0]   mag[3];
        bit            neg[3];
        logic [63:0]   sq;
        logic [63:0]   t;
        logic [63:0]   len;
        logic [127:0]  q;
        logic [UW-1:0] comp[3];
        int            m;
        int            e;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            logic [31:0] c;
            c = v[i*COMP_W +: COMP_W];
            neg[i] = c[31];
            mag[i] = neg[i] ? (64'd1 << 32) - {32'd0, c} : {32'd0, c};
            sq = sq + mag[i] * mag[i];
        end
        r = '0;
        if (sq == 0) begin
            r.zero = 1'b1;
            return r;
        end
        if (sq == (64'd1 << (2*FB))) begin
            for (int i = 0; i < 3; i++)
                comp[i] = neg[i] ? UW'(-mag[i]) : UW'(mag[i]);
            r.inv_len = INV_W'(64'd1 << FB);
        end else begin
            t = sq;
            m = 0;
            while (t < (64'd1 << 62) && m < 31) begin
                t = t << 2;
                m++;
            end
            len = root_floor(t);
            if (len == 0) len = 1;
            for (int i = 0; i < 3; i++) begin
                q = ({64'd0, mag[i]} << (FB + m)) / {64'd0, len};
                comp[i] = neg[i] ? UW'(-q) : UW'(q);
            end
            e = 2*FB + m;
            if (e >= 64) begin
                r.inv_len = '1;
            end else begin
                q = (128'd1 << e) / {64'd0, len};
                r.inv_len = (q > 128'hFFFF_FFFF) ? '1 : q[31:0];
            end
        end
        r.ux = comp[0];
        r.uy = comp[1];
        r.uz = comp[2];
        return r;
    endfunction

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 255)) - 128);
            2: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            3: return ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            4: return 32'($urandom) >>> $urandom_range(0, 31);
            default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic void push_vec(input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] z);
        vec_queue.push_back({z, y, x});
    endfunction

    // Fill the pending vectors: directed corners, then random
    initial begin
        push_vec(0, 0, 0);
        push_vec(32'h0001_0000, 0, 0);
        push_vec(0, 32'hFFFF_0000, 0);
        push_vec(0, 0, 32'h0001_0000);
        push_vec(32'h0000_9DE0, 32'h0000_7D70, 0);
        push_vec(1, 0, 0);
        push_vec(32'hFFFF_FFFF, 1, 0);
        push_vec(0, 0, 1);
        push_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_vec(32'h8000_0000, 0, 0);
        push_vec(32'h7FFF_FFFF, 32'h8000_0000, 1);
        push_vec(32'h0000_FFFF, 0, 0);
        push_vec(32'h0001_0001, 0, 0);
        push_vec(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
        push_vec(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        push_vec(3, 4, 0);
        for (int n = 0; n < 1200; n++) begin
            if ($urandom_range(0, 19) == 0)
                push_vec(0, 0, 0);
            else
                push_vec(rand_comp(), rand_comp(), rand_comp());
        end
    end

    // Reset and drive the input beats
    initial begin
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                unit_expected.push_back(normalize_vec(s_axis_tdata));
                void'(vec_queue.pop_front());
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the beat
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else begin
                int qn;
                qn = vec_queue.size();
                if (qn > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= vec_queue[0];
                    send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                end else begin
                    s_axis_tvalid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // Output side: random ready, one long hold-off after some traffic
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && checked == 200) begin
                hold_cycles <= hold_cycles + 1;
                m_axis_tready <= 1'b0;
                if (hold_cycles >= 400) hold_done <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready)
                    recv_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0;
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_unit_res got;
        t_unit_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.ux = m_axis_tdata[0 +: UW];
            got.uy = m_axis_tdata[UW +: UW];
            got.uz = m_axis_tdata[2*UW +: UW];
            got.inv_len = m_axis_tdata[3*UW +: INV_W];
            got.zero = m_axis_tuser[0];
            checked <= checked + 1;
            if (got.zero) zero_seen <= zero_seen + 1;
            if (unit_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %h", got);
            end else begin
                want = unit_expected.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp ux=%h uy=%h uz=%h inv=%h z=%b,",
                                 want.ux, want.uy, want.uz, want.inv_len, want.zero,
                                 " got ux=%h uy=%h uz=%h inv=%h z=%b",
                                 got.ux, got.uy, got.uz, got.inv_len, got.zero);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WD_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Drain and report
    initial begin
        wait (stim_done);
        wait (unit_expected.size() == 0);
        repeat (2*LATENCY) @(posedge i_clk);
        $display("Checked %0d normalized vectors (%0d zero vectors), incl. corners,",
                 checked, zero_seen);
        $display("random idling on both sides and one long output stall.");
        if (mismatches == 0 && unit_expected.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/vn_pkg.sv
rtl/vn_front.sv
rtl/vn_sqrt.sv
rtl/vn_div.sv
rtl/vec3_normalize_top.sv
rtl/vn_checker.sv
tb/testbench.sv
